### hw/rtl/chte_pkg.sv
package chte_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 9;
  localparam logic [8:0] BUCKETS_RST = 9'd100;

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_LOOKUP = 3'd2;
  localparam logic [2:0] ACT_UPDATE = 3'd3;
  localparam logic [2:0] ACT_PAIR   = 3'd4;
  localparam logic [2:0] ACT_COUNT  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_HEAD  = 13'b0000000001000,
    S_HEAD2 = 13'b0000000010000,
    S_ADD   = 13'b0000000100000,
    S_ADD2  = 13'b0000001000000,
    S_WALK  = 13'b0000010000000,
    S_CHK   = 13'b0000100000000,
    S_REM1  = 13'b0001000000000,
    S_REM2  = 13'b0010000000000,
    S_NKEY  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

endpackage

### hw/rtl/chained_hash_table_engine_core.sv
// Hash table with separate chaining, one action at a time. After reset the
// block clears the bucket heads and loads the free pool, with busy high. An
// accepted action first reduces the key modulo the bucket count bit-serially
// (one remainder bit per cycle) and then reads the bucket head. An add then
// writes the new entry and links it in as the newest. Every other action then
// walks the chain, a walk and a check state per entry visited, stopping at
// a match or the chain's end (a count walks the whole chain); a remove then
// updates its links and, where it removed the newest entry, reloads the
// newest key. An add to a full table and an unused action code skip the
// modulo and report in the cycle right after acceptance. Busy stays high
// through the result cycle. The result appears for exactly one cycle with
// done high and must be taken then: the receiver cannot stall the block.
module chained_hash_table_engine_core #(
  parameter int MAX_BUCKETS = 256,
  parameter int MAX_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic signed [31:0] key,
  input  logic signed [31:0] data_word0,
  input  logic signed [31:0] data_word1,
  input  logic signed [31:0] data_word2,
  input  logic signed [31:0] data_word3,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic [8:0]         match_count,
  output logic signed [31:0] found_word0,
  output logic signed [31:0] found_word1,
  output logic signed [31:0] found_word2,
  output logic signed [31:0] found_word3,
  output logic [8:0]         element_count,
  output logic signed [31:0] newest_key,
  output logic               table_empty
);

  localparam int BW  = $clog2(MAX_BUCKETS + 1);
  localparam int BIW = $clog2(MAX_BUCKETS);
  localparam int EIW = $clog2(MAX_ENTRIES);
  localparam int LW  = EIW + 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int CLN = (MAX_BUCKETS > MAX_ENTRIES) ? MAX_BUCKETS : MAX_ENTRIES;
  localparam int CLW = $clog2(CLN);
  localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);

  chte_pkg::state_t state;

  logic [8:0]   buckets;
  logic [BW-1:0] n_eff;
  logic [CLW-1:0] clr;

  logic [2:0]   act;
  logic [31:0]  k, w0, w1, w2, w3;
  logic [BIW-1:0] b;
  logic [LW-1:0] cur, prv, p, q, nxt_chain;
  logic [EIW-1:0] n;
  logic [LW-1:0] newest;
  logic [CW-1:0] stored;
  logic [31:0]  nkey;

  logic         mod_start, mod_done;
  logic [BW-1:0] mod_rem;

  logic [LW-1:0]  heads [MAX_BUCKETS];
  logic [EIW-1:0] pool  [MAX_ENTRIES];
  logic [31:0]    keys  [MAX_ENTRIES];
  logic [127:0]   words [MAX_ENTRIES];
  logic [LW-1:0]  chain [MAX_ENTRIES];
  logic [LW-1:0]  prevl [MAX_ENTRIES];
  logic [LW-1:0]  nextl [MAX_ENTRIES];

  logic [LW-1:0]  head_rd, chain_rd, prev_rd, next_rd;
  logic [EIW-1:0] pool_rd;
  logic [31:0]    key_rd;
  logic [127:0]   words_rd;
  logic [EIW-1:0] key_ra, pool_ra;

  logic hit, match;
  logic cur_ok, prv_ok, p_ok, q_ok;

  assign busy      = (state != chte_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign done      = (state == chte_pkg::S_DONE);

  assign element_count = 9'(stored);
  assign table_empty   = (stored == '0);
  assign newest_key    = $signed(nkey);

  assign cur_ok = (cur < NIL);
  assign prv_ok = (prv < NIL);
  assign p_ok   = (p < NIL);
  assign q_ok   = (q < NIL);
  assign hit    = (key_rd == k);
  assign match  = hit && ((act != chte_pkg::ACT_PAIR) || (words_rd[31:0] == w0));

  always_comb begin
    if (buckets == 9'd0) n_eff = BW'(1);
    else if (32'(buckets) > MAX_BUCKETS) n_eff = BW'(MAX_BUCKETS);
    else n_eff = BW'(buckets);
  end

  assign mod_start = (state == chte_pkg::S_IDLE) && start && (action != chte_pkg::ACT_ADD ||
                     32'(stored) < MAX_ENTRIES) && (action <= chte_pkg::ACT_COUNT);

  chte_mod #(.DW(BW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  ($unsigned(key)),
    .divisor   (n_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign pool_ra = EIW'(CW'(MAX_ENTRIES - 1) - stored);
  assign key_ra  = (state == chte_pkg::S_REM2) ? q[EIW-1:0] : cur[EIW-1:0];

  always_ff @(posedge clk) begin
    if (state == chte_pkg::S_CLEAR && 32'(clr) < MAX_BUCKETS) heads[BIW'(clr)] <= NIL;
    else if (state == chte_pkg::S_ADD) heads[b] <= LW'(n);
    else if (state == chte_pkg::S_REM1 && !prv_ok) heads[b] <= nxt_chain;
    head_rd <= heads[b];
  end

  always_ff @(posedge clk) begin
    if (state == chte_pkg::S_CLEAR && 32'(clr) < MAX_ENTRIES) pool[EIW'(clr)] <= EIW'(clr);
    else if (state == chte_pkg::S_REM2) pool[EIW'(CW'(MAX_ENTRIES) - stored)] <= cur[EIW-1:0];
    pool_rd <= pool[pool_ra];
  end

  always_ff @(posedge clk) begin
    if (state == chte_pkg::S_ADD) keys[n] <= k;
    key_rd <= keys[key_ra];
  end

  always_ff @(posedge clk) begin
    if (state == chte_pkg::S_ADD) words[n] <= {w3, w2, w1, w0};
    else if (state == chte_pkg::S_CHK && match && act == chte_pkg::ACT_UPDATE)
      words[cur[EIW-1:0]] <= {w3, w2, w1, w0};
    words_rd <= words[cur[EIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == chte_pkg::S_ADD) chain[n] <= cur;
    else if (state == chte_pkg::S_REM1 && prv_ok) chain[prv[EIW-1:0]] <= nxt_chain;
    chain_rd <= chain[cur[EIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == chte_pkg::S_ADD) prevl[n] <= NIL;
    else if (state == chte_pkg::S_ADD2 && newest < NIL) prevl[newest[EIW-1:0]] <= LW'(n);
    else if (state == chte_pkg::S_REM2 && q_ok) prevl[q[EIW-1:0]] <= p;
    prev_rd <= prevl[cur[EIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == chte_pkg::S_ADD) nextl[n] <= newest;
    else if (state == chte_pkg::S_REM1 && p_ok) nextl[p[EIW-1:0]] <= q;
    next_rd <= nextl[cur[EIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= chte_pkg::S_CLEAR;
      clr         <= '0;
      buckets     <= chte_pkg::BUCKETS_RST;
      newest      <= NIL;
      stored      <= '0;
      nkey        <= '0;
      status      <= chte_pkg::ST_MISS;
      match_count <= '0;
      found_word0 <= '0;
      found_word1 <= '0;
      found_word2 <= '0;
      found_word3 <= '0;
    end else begin
      if (cfg_valid && cfg_ready) buckets <= cfg_data;
      unique case (state)
        chte_pkg::S_CLEAR: begin
          clr <= clr + CLW'(1);
          if (clr == CLW'(CLN - 1)) state <= chte_pkg::S_IDLE;
        end
        chte_pkg::S_IDLE: begin
          if (start) begin
            act         <= action;
            k           <= $unsigned(key);
            w0          <= $unsigned(data_word0);
            w1          <= $unsigned(data_word1);
            w2          <= $unsigned(data_word2);
            w3          <= $unsigned(data_word3);
            match_count <= '0;
            found_word0 <= '0;
            found_word1 <= '0;
            found_word2 <= '0;
            found_word3 <= '0;
            if (action > chte_pkg::ACT_COUNT) begin
              status <= chte_pkg::ST_MISS;
              state  <= chte_pkg::S_DONE;
            end else if (action == chte_pkg::ACT_ADD && 32'(stored) >= MAX_ENTRIES) begin
              status <= chte_pkg::ST_FULL;
              state  <= chte_pkg::S_DONE;
            end else begin
              status <= chte_pkg::ST_MISS;
              state  <= chte_pkg::S_DIV;
            end
          end
        end
        chte_pkg::S_DIV: begin
          if (mod_done) begin
            b     <= BIW'(mod_rem);
            state <= chte_pkg::S_HEAD;
          end
        end
        chte_pkg::S_HEAD: state <= chte_pkg::S_HEAD2;
        chte_pkg::S_HEAD2: begin
          cur <= head_rd;
          n   <= pool_rd;
          prv <= NIL;
          if (act == chte_pkg::ACT_ADD) state <= chte_pkg::S_ADD;
          else state <= chte_pkg::S_WALK;
        end
        chte_pkg::S_ADD: state <= chte_pkg::S_ADD2;
        chte_pkg::S_ADD2: begin
          newest <= LW'(n);
          nkey   <= k;
          stored <= stored + CW'(1);
          status <= chte_pkg::ST_OK;
          state  <= chte_pkg::S_DONE;
        end
        chte_pkg::S_WALK: begin
          if (cur_ok) state <= chte_pkg::S_CHK;
          else begin
            if (act == chte_pkg::ACT_COUNT) status <= chte_pkg::ST_OK;
            state <= chte_pkg::S_DONE;
          end
        end
        chte_pkg::S_CHK: begin
          if (act == chte_pkg::ACT_COUNT) begin
            match_count <= match_count + 9'(hit);
            prv   <= cur;
            cur   <= chain_rd;
            state <= chte_pkg::S_WALK;
          end else if (match) begin
            status    <= chte_pkg::ST_OK;
            p         <= prev_rd;
            q         <= next_rd;
            nxt_chain <= chain_rd;
            if (act == chte_pkg::ACT_LOOKUP) begin
              found_word0 <= $signed(words_rd[31:0]);
              found_word1 <= $signed(words_rd[63:32]);
              found_word2 <= $signed(words_rd[95:64]);
              found_word3 <= $signed(words_rd[127:96]);
            end
            if (act == chte_pkg::ACT_REMOVE) state <= chte_pkg::S_REM1;
            else state <= chte_pkg::S_DONE;
          end else begin
            prv   <= cur;
            cur   <= chain_rd;
            state <= chte_pkg::S_WALK;
          end
        end
        chte_pkg::S_REM1: begin
          if (!p_ok) newest <= q;
          state <= chte_pkg::S_REM2;
        end
        chte_pkg::S_REM2: begin
          if (stored != '0) stored <= stored - CW'(1);
          if (newest == q) begin
            if (q_ok) state <= chte_pkg::S_NKEY;
            else begin
              nkey  <= '0;
              state <= chte_pkg::S_DONE;
            end
          end else state <= chte_pkg::S_DONE;
        end
        chte_pkg::S_NKEY: begin
          nkey  <= key_rd;
          state <= chte_pkg::S_DONE;
        end
        chte_pkg::S_DONE: state <= chte_pkg::S_IDLE;
        default: state <= chte_pkg::S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/chte_mod.sv
module chte_mod #(
  parameter int DW = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [chte_pkg::KEY_W-1:0]  dividend,
  input  logic [DW-1:0]               divisor,
  output logic                        done,
  output logic [DW-1:0]               remainder
);

  localparam int SW = $clog2(chte_pkg::KEY_W) + 1;

  logic [chte_pkg::KEY_W-1:0] quo;
  logic [DW-1:0]              dv;
  logic [DW:0]                rem;
  logic [DW:0]                shifted;
  logic [SW-1:0]              steps;
  logic                       run;

  assign shifted   = {rem[DW-1:0], quo[chte_pkg::KEY_W-1]};
  assign remainder = rem[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        steps <= '0;
        quo   <= dividend;
        dv    <= divisor;
        rem   <= '0;
      end else if (run) begin
        quo <= {quo[chte_pkg::KEY_W-2:0], 1'b0};
        if (shifted >= {1'b0, dv}) rem <= shifted - {1'b0, dv};
        else rem <= shifted;
        if (steps == SW'(chte_pkg::KEY_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        steps <= steps + SW'(1);
      end
    end
  end

endmodule

### bench/chained_hash_table_engine_core_tb.sv
module chained_hash_table_engine_core_tb;

  localparam int NBUCK = 256;
  localparam int NENT = 256;
  localparam int NIL = NENT;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [2:0] ACT_UNUSED6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  match_count;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [8:0]  element_count;
    logic [31:0] newest_key;
    logic        table_empty;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] action = '0;
  logic signed [31:0] key = '0;
  logic signed [31:0] data_word0 = '0;
  logic signed [31:0] data_word1 = '0;
  logic signed [31:0] data_word2 = '0;
  logic signed [31:0] data_word3 = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic [8:0] match_count;
  logic signed [31:0] found_word0, found_word1, found_word2, found_word3;
  logic [8:0] element_count;
  logic signed [31:0] newest_key;
  logic table_empty;

  chained_hash_table_engine_core dut (.*);

  always #4 clk = ~clk;

  // table shadow
  int          heads[NBUCK];
  logic [31:0] ekey[NENT];
  logic [31:0] ew0[NENT], ew1[NENT], ew2[NENT], ew3[NENT];
  int          chain[NENT];
  int          oprev[NENT], onext[NENT];
  int          pool[NENT];
  int          newest, oldest, stored;
  logic [8:0]  buckets;

  reply_t replies_due[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  logic [31:0] keys_used[$];

  function automatic int bucket_for(logic [31:0] k);
    int n;
    n = buckets;
    if (n == 0) n = 1;
    if (n > NBUCK) n = NBUCK;
    return int'(k % n);
  endfunction

  task automatic table_reset();
    for (int i = 0; i < NBUCK; i++) heads[i] = NIL;
    for (int i = 0; i < NENT; i++) pool[i] = i;
    newest = NIL;
    oldest = NIL;
    stored = 0;
    buckets = chte_pkg::BUCKETS_RST;
  endtask

  function automatic reply_t table_apply(logic [2:0] act, logic [31:0] k, logic [31:0] d0,
                                         logic [31:0] d1, logic [31:0] d2, logic [31:0] d3);
    reply_t r;
    int b, cur, prv, n, p, q, cnt;
    bit hit;
    r = '0;
    r.status = chte_pkg::ST_MISS;
    cnt = 0;
    b = bucket_for(k);
    if (act == chte_pkg::ACT_ADD) begin
      if (stored >= NENT) begin
        r.status = chte_pkg::ST_FULL;
      end else begin
        n = pool[NENT - 1 - stored];
        ekey[n] = k;
        ew0[n] = d0; ew1[n] = d1; ew2[n] = d2; ew3[n] = d3;
        chain[n] = heads[b];
        heads[b] = n;
        oprev[n] = NIL;
        onext[n] = newest;
        if (newest != NIL) oprev[newest] = n;
        else oldest = n;
        newest = n;
        stored++;
        r.status = chte_pkg::ST_OK;
      end
    end else if (act <= chte_pkg::ACT_COUNT) begin
      prv = NIL;
      cur = heads[b];
      for (int s = 0; cur != NIL && s < NENT; s++) begin
        hit = (ekey[cur] == k);
        if (act == chte_pkg::ACT_COUNT) begin
          if (hit) cnt++;
        end else if (hit && (act != chte_pkg::ACT_PAIR || ew0[cur] == d0)) begin
          r.status = chte_pkg::ST_OK;
          if (act == chte_pkg::ACT_REMOVE) begin
            p = oprev[cur];
            q = onext[cur];
            if (prv != NIL) chain[prv] = chain[cur];
            else heads[b] = chain[cur];
            if (p != NIL) onext[p] = q;
            else newest = q;
            if (q != NIL) oprev[q] = p;
            else oldest = p;
            if (stored > 0) begin
              stored--;
              pool[NENT - 1 - stored] = cur;
            end
          end else if (act == chte_pkg::ACT_LOOKUP) begin
            r.w0 = ew0[cur]; r.w1 = ew1[cur]; r.w2 = ew2[cur]; r.w3 = ew3[cur];
          end else if (act == chte_pkg::ACT_UPDATE) begin
            ew0[cur] = d0; ew1[cur] = d1; ew2[cur] = d2; ew3[cur] = d3;
          end
          break;
        end
        prv = cur;
        cur = chain[cur];
      end
      if (act == chte_pkg::ACT_COUNT) r.status = chte_pkg::ST_OK;
    end
    r.match_count = cnt[8:0];
    r.element_count = stored[8:0];
    r.newest_key = (newest != NIL) ? ekey[newest] : '0;
    r.table_empty = (stored == 0);
    return r;
  endfunction

  task automatic pause_maybe();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(posedge clk);
  endtask

  task automatic send_action(logic [2:0] act, logic [31:0] k, logic [31:0] d0 = $urandom,
                             logic [31:0] d1 = $urandom, logic [31:0] d2 = $urandom,
                             logic [31:0] d3 = $urandom);
    pause_maybe();
    action <= act;
    key <= k;
    data_word0 <= d0;
    data_word1 <= d1;
    data_word2 <= d2;
    data_word3 <= d3;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    replies_due.push_back(table_apply(act, k, d0, d1, d2, d3));
    if (act == chte_pkg::ACT_ADD) keys_used.push_back(k);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_buckets(logic [8:0] v);
    wait_drained();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    buckets = v;
  endtask

  function automatic logic [31:0] pick_key();
    if (keys_used.size() != 0 && $urandom_range(0, 3) != 0)
      return keys_used[$urandom_range(0, keys_used.size() - 1)];
    return $urandom_range(0, 1) ? $urandom_range(0, 600) : $urandom;
  endfunction

  always @(posedge clk) begin
    reply_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && done) begin
      got = {status, match_count, found_word0, found_word1, found_word2, found_word3,
             element_count, newest_key, table_empty};
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_action(chte_pkg::ACT_LOOKUP, 32'd5);
    send_action(chte_pkg::ACT_REMOVE, 32'd5);
    send_action(chte_pkg::ACT_COUNT, 32'd5);
    send_action(chte_pkg::ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, '1, '0);
    send_action(chte_pkg::ACT_ADD, 32'h7fff_ffff, '1, '0, 32'h8000_0000, 32'h7fff_ffff);
    send_action(chte_pkg::ACT_ADD, 32'd5, 32'd1, 32'd2, 32'd3, 32'd4);
    send_action(chte_pkg::ACT_ADD, 32'd5, 32'd9, 32'd8, 32'd7, 32'd6);
    send_action(chte_pkg::ACT_ADD, 32'd105, 32'd0, 32'd0, 32'd0, 32'd0);
    send_action(chte_pkg::ACT_COUNT, 32'd5);
    send_action(chte_pkg::ACT_LOOKUP, 32'd5);
    send_action(chte_pkg::ACT_PAIR, 32'd5, 32'd1);
    send_action(chte_pkg::ACT_PAIR, 32'd5, 32'd2);
    send_action(chte_pkg::ACT_UPDATE, 32'd5, 32'hdead_beef, 32'd1, 32'd1, 32'd1);
    send_action(chte_pkg::ACT_LOOKUP, 32'h8000_0000);
    send_action(chte_pkg::ACT_REMOVE, 32'd105);
    send_action(ACT_UNUSED6, 32'd5);
    send_action(ACT_UNUSED7, 32'd5);
    send_action(chte_pkg::ACT_UPDATE, 32'd77);
    send_action(chte_pkg::ACT_REMOVE, 32'd5);
    send_action(chte_pkg::ACT_LOOKUP, 32'd5);
  endtask

  task automatic test_stale_chains();
    write_buckets(9'd0);
    send_action(chte_pkg::ACT_LOOKUP, 32'd5);
    send_action(chte_pkg::ACT_ADD, 32'd12);
    send_action(chte_pkg::ACT_COUNT, 32'd12);
    write_buckets(9'd511);
    send_action(chte_pkg::ACT_LOOKUP, 32'd12);
    send_action(chte_pkg::ACT_ADD, 32'd300);
    send_action(chte_pkg::ACT_COUNT, 32'd300);
  endtask

  task automatic test_fill_pool();
    write_buckets(9'd1);
    while (stored < NENT) send_action(chte_pkg::ACT_ADD, $urandom_range(0, 40));
    send_action(chte_pkg::ACT_ADD, 32'd1);
    send_action(chte_pkg::ACT_COUNT, 32'd7);
    for (int i = 0; i < 20; i++) send_action(chte_pkg::ACT_REMOVE, $urandom_range(0, 40));
    write_buckets(9'd256);
    for (int i = 0; i < 25; i++) send_action(chte_pkg::ACT_REMOVE, pick_key());
  endtask

  task automatic test_random(int n);
    logic [2:0] a;
    logic [8:0] settings[5] = '{9'd1, 9'd3, 9'd17, 9'd100, 9'd256};
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) write_buckets(settings[$urandom_range(0, 4)]);
      if (i == n - 100) idle_on = 1'b0;
      a = (stored > 200) ? 3'($urandom_range(1, 5)) : 3'($urandom_range(0, 7));
      if (a > chte_pkg::ACT_COUNT && $urandom_range(0, 3) != 0) a = chte_pkg::ACT_ADD;
      if (a == chte_pkg::ACT_PAIR && stored != 0 && $urandom_range(0, 1)) begin
        logic [31:0] k;
        int j;
        k = pick_key();
        j = heads[bucket_for(k)];
        if (j != NIL) send_action(chte_pkg::ACT_PAIR, ekey[j], ew0[j]);
        else send_action(chte_pkg::ACT_PAIR, k);
      end else begin
        send_action(a, pick_key());
      end
    end
  endtask

  initial begin
    table_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_stale_chains();
    test_fill_pool();
    test_random(520);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/chte_pkg.sv
hw/rtl/chte_mod.sv
hw/rtl/chained_hash_table_engine_core.sv
bench/chained_hash_table_engine_core_tb.sv
